### hw/rtl/fcs_pkg.sv
package fcs_pkg;

	// character codes that steer the scanner
	localparam logic [15:0] CH_SLASH  = 16'h002F;
	localparam logic [15:0] CH_STAR   = 16'h002A;
	localparam logic [15:0] CH_APOS   = 16'h0027;
	localparam logic [15:0] CH_DQUOTE = 16'h0022;
	localparam logic [15:0] CH_BAR    = 16'h007C;
	localparam logic [15:0] CH_CR     = 16'h000D;
	localparam logic [15:0] CH_LF     = 16'h000A;
	localparam logic [15:0] CH_SPACE  = 16'h0020;

	// result queue depth and pointer widths
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_APOS    = 3'd1,
		MODE_DQUOTE  = 3'd2,
		MODE_BAR     = 3'd3,
		MODE_COMMENT = 3'd4
	} scan_mode_t;

	// one result item
	typedef struct packed {
		logic [15:0] ch;
		logic        valid;
		logic        last;
	} result_t;

	// results produced by one input character, zero to two
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	// scanner state, visible for checks
	typedef struct packed {
		scan_mode_t mode;
		logic       slash;
	} scan_status_t;

endpackage

### hw/rtl/format_comment_stripper_core.sv
// Streaming comment stripper for 16-bit character text. One character is
// taken per transfer on the input channel; slash-star outside a quoted span
// (apostrophe, double quote or bar) drops everything up to the line end, whose
// CR or LF is kept unless prepare mode drops it. A slash is held back until
// the next character, so one input can give two results; each input gives
// zero to two results, and a text whose final character gives nothing ends
// with an empty marker (out_valid low, last_out high). A character is
// registered, scanned and written into a four-entry result queue; input is
// taken every cycle while the queue has room for two results, so the
// sustained rate is one character per cycle whenever results are drained at
// least as fast as they are produced. drop_control_chars (prepare mode) must
// be written only while the block is idle; the block does not enforce this.
module format_comment_stripper_core import fcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        drop_control_chars,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] ch,
	input  logic        last_in,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [15:0] out_ch,
	output logic        out_valid,
	output logic        last_out
);

	logic             drop_q;
	logic             room;
	logic             push_en;
	push_t            push;
	scan_status_t     status;
	logic [CNT_W-1:0] count;

	assign cfg_ready = 1'b1;

	// prepare mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			drop_q <= drop_control_chars;
		end
	end

	fcs_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.last_in   (last_in),
		.drop_ctrl (drop_q),
		.room      (room),
		.push_en   (push_en),
		.push      (push),
		.status    (status)
	);

	fcs_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (push_en),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_ch    (out_ch),
		.out_valid (out_valid),
		.last_out  (last_out),
		.count     (count)
	);

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	// end of text leaves the scanner in its reset state
	assert property (@(posedge clk) disable iff (!arst_n)
		(push_en && push.r1.last) |=> (status.mode == MODE_NORMAL && !status.slash))
		else $error("scanner state not cleared after end of text");

	// a held slash only exists outside quotes and comments
	assert property (@(posedge clk) disable iff (!arst_n)
		status.slash |-> (status.mode == MODE_NORMAL))
		else $error("slash held inside quoted span or comment");

	// an empty marker always closes a text
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> last_out)
		else $error("empty marker without end of text");

endmodule

### hw/rtl/fcs_scan.sv
module fcs_scan import fcs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [15:0]  ch,
	input  logic         last_in,
	input  logic         drop_ctrl,
	input  logic         room,
	output logic         push_en,
	output push_t        push,
	output scan_status_t status
);

	logic        valid_s1;
	logic [15:0] ch_s1;
	logic        last_s1;
	scan_mode_t  mode_q, mode_d;
	logic        slash_q, slash_d;
	logic        adv;

	assign adv      = valid_s1 & room;
	assign in_ready = ~valid_s1 | adv;
	assign push_en  = adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last_in;
		end
	end

	// scan state, advanced once per character handed to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			slash_q <= 1'b0;
		end else if (adv) begin
			mode_q  <= mode_d;
			slash_q <= slash_d;
		end
	end

	// next state and result selection
	always_comb begin
		logic       rel_slash;
		logic       emit_ch;
		logic       end_slash;
		logic       is_ctrl;
		logic [1:0] num;
		logic [15:0] close_ch;

		rel_slash = 1'b0;
		emit_ch   = 1'b0;
		mode_d    = mode_q;
		slash_d   = slash_q;
		is_ctrl   = (ch_s1[15:5] == 11'd0);

		case (mode_q)
			MODE_APOS:   close_ch = CH_APOS;
			MODE_DQUOTE: close_ch = CH_DQUOTE;
			default:     close_ch = CH_BAR;
		endcase

		unique case (mode_q) inside
			MODE_COMMENT: begin
				if (ch_s1 == CH_CR || ch_s1 == CH_LF) begin
					emit_ch = 1'b1;
					mode_d  = MODE_NORMAL;
				end
			end
			MODE_APOS, MODE_DQUOTE, MODE_BAR: begin
				emit_ch = 1'b1;
				if (ch_s1 == close_ch) begin
					mode_d = MODE_NORMAL;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				if (slash_q && ch_s1 == CH_STAR) begin
					slash_d = 1'b0;
					mode_d  = MODE_COMMENT;
				end else begin
					rel_slash = slash_q;
					slash_d   = (ch_s1 == CH_SLASH);
					emit_ch   = (ch_s1 != CH_SLASH);
					if (ch_s1 == CH_APOS) begin
						mode_d = MODE_APOS;
					end else if (ch_s1 == CH_DQUOTE) begin
						mode_d = MODE_DQUOTE;
					end else if (ch_s1 == CH_BAR) begin
						mode_d = MODE_BAR;
					end
				end
			end
		endcase

		// prepare mode drops control characters
		if (drop_ctrl && is_ctrl) begin
			emit_ch = 1'b0;
		end

		end_slash = last_s1 & slash_d;
		num = {1'b0, rel_slash} + {1'b0, emit_ch} + {1'b0, end_slash};

		// end of text returns the scanner to its reset state
		if (last_s1) begin
			mode_d  = MODE_NORMAL;
			slash_d = 1'b0;
		end

		// pack results in emission order
		push.r0.ch    = rel_slash ? CH_SLASH : (emit_ch ? ch_s1 : CH_SLASH);
		push.r0.valid = 1'b1;
		push.r0.last  = last_s1 && (num == 2'd1);
		push.r1.ch    = (rel_slash && emit_ch) ? ch_s1 : CH_SLASH;
		push.r1.valid = 1'b1;
		push.r1.last  = last_s1;
		push.num      = num;

		// empty end marker when the final character leaves nothing
		if (last_s1 && num == 2'd0) begin
			push.r0.ch    = 16'd0;
			push.r0.valid = 1'b0;
			push.r0.last  = 1'b1;
			push.num      = 2'd1;
		end
	end

	assign status.mode  = mode_q;
	assign status.slash = slash_q;

endmodule

### hw/rtl/fcs_result_fifo.sv
module fcs_result_fifo import fcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_en,
	input  push_t       push,
	output logic        room,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [15:0] out_ch,
	output logic        out_valid,
	output logic        last_out,
	output logic [CNT_W-1:0] count
);

	result_t          mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       num;
	logic             pop;

	assign num       = push_en ? push.num : 2'd0;
	assign pop       = res_valid & res_ready;
	assign res_valid = (count_q != '0);
	assign room      = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign count     = count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(num);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(num) - CNT_W'(pop);
		end
	end

	// storage, up to two writes per cycle
	always_ff @(posedge clk) begin
		if (num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (num == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	assign out_ch    = mem_q[rd_ptr_q].ch;
	assign out_valid = mem_q[rd_ptr_q].valid;
	assign last_out  = mem_q[rd_ptr_q].last;

endmodule
